>>> src/ptst_pkg.sv
// Shared types and constants for the per-PC latency statistics table.
// Used by the table memory, the update datapath and the top level.
`default_nettype none

package ptst_pkg;

  localparam int IDX_W   = 12;
  localparam int CNT_W   = 27;
  localparam int OP_W    = 8;
  localparam int DUR_W   = 32;
  localparam int TOTAL_W = 59;
  localparam int SQ_W    = 64;
  localparam int CFG_W   = 27;

  localparam logic [CNT_W-1:0] RESET_COUNT_LIMIT = 27'd100000000;
  localparam logic [OP_W-1:0]  NOP_OPCODE        = 8'd0;

  // Item functions.
  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_ENABLE      = 1'b0;
  localparam logic CFG_COUNT_LIMIT = 1'b1;

  // One table entry as held in memory.
  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [OP_W-1:0]    opcode;
    logic [TOTAL_W-1:0] total;
    logic [SQ_W-1:0]    squares;
    logic [DUR_W-1:0]   smallest;
    logic [DUR_W-1:0]   largest;
  } entry_t;

  // Latched request fields seen by the update datapath.
  typedef struct packed {
    logic               func;
    logic [OP_W-1:0]    opcode;
    logic [DUR_W-1:0]   duration;
    logic [SQ_W-1:0]    square;
  } req_t;

  // Configuration as seen by the update datapath.
  typedef struct packed {
    logic               enable;
    logic [CNT_W-1:0]   count_limit;
  } cfg_t;

endpackage

`default_nettype wire

>>> src/ptst_mem.sv
// Synchronous single-write, single-read memory holding the table entries.
// Depends on ptst_pkg for the entry type; read data is registered and appears in the cycle after the read.
`default_nettype none

module ptst_mem
  import ptst_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> src/ptst_upd.sv
// Read-modify-write datapath: folds one sample into an entry, updates the
// NOP base cost and forms the result view. Depends on ptst_pkg.
`default_nettype none

module ptst_upd
  import ptst_pkg::*;
(
  input  wire entry_t             old_entry,
  input  wire req_t               req,
  input  wire cfg_t               cfg,
  input  wire logic [DUR_W-1:0]   base_cost,
  output entry_t                  new_entry,
  output logic                    wr_en,
  output entry_t                  view,
  output logic [DUR_W-1:0]        base_cost_nxt
);

  logic   record;
  logic   grow;
  logic   nop_hit;
  entry_t shown;

  always_comb begin
    record  = (req.func == FUNC_RECORD) && cfg.enable;
    grow    = record && (old_entry.count < cfg.count_limit);
    nop_hit = record && (req.opcode == NOP_OPCODE) &&
              ((base_cost == '0) || (req.duration < base_cost));

    new_entry       = old_entry;
    new_entry.count = old_entry.count + 27'd1;
    if (old_entry.count == '0) begin
      new_entry.opcode   = req.opcode;
      new_entry.total    = TOTAL_W'(req.duration);
      new_entry.squares  = req.square;
      new_entry.smallest = req.duration;
      new_entry.largest  = req.duration;
    end else begin
      new_entry.total   = old_entry.total + TOTAL_W'(req.duration);
      new_entry.squares = old_entry.squares + req.square;
      if (req.duration < old_entry.smallest) begin
        new_entry.smallest = req.duration;
      end
      if (req.duration > old_entry.largest) begin
        new_entry.largest = req.duration;
      end
    end

    wr_en = grow;
    shown = grow ? new_entry : old_entry;

    // Fields of an empty entry were never written and are shown as zero.
    view = '0;
    view.count = shown.count;
    if (shown.count != '0) begin
      view = shown;
    end

    base_cost_nxt = nop_hit ? req.duration : base_cost;
  end

endmodule

`default_nettype wire

>>> src/per_pc_latency_statistics_table.sv
// Per-PC latency statistics table: top level with control, config and outputs.
// Depends on ptst_pkg, ptst_mem and ptst_upd.
`default_nettype none

// An item is taken when start is high and busy is low. In the idle state the
// entry is read from the table memory and the duration is squared; in the
// update state the entry is updated and written back. The result is strobed
// on out_valid for one cycle in the cycle after that, and the next item may
// be started in that same cycle. Busy is high in the update state, so no new
// item is taken before the last is written back. After reset the block sweeps
// the table to clear every entry, one entry per cycle, and busy stays high
// until the sweep ends (ENTRIES entries, 4096 by default); configuration writes
// are taken during the sweep. Results cannot be held off by the receiver.
module per_pc_latency_statistics_table
  import ptst_pkg::*;
#(
  parameter int ENTRIES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_func,
  input  wire logic [IDX_W-1:0]    in_entry_index,
  input  wire logic [OP_W-1:0]     in_opcode,
  input  wire logic [DUR_W-1:0]    in_duration,
  output logic                     out_valid,
  output logic [CNT_W-1:0]         out_count,
  output logic [OP_W-1:0]          out_entry_opcode,
  output logic [TOTAL_W-1:0]       out_total,
  output logic [SQ_W-1:0]          out_total_squares,
  output logic [DUR_W-1:0]         out_smallest,
  output logic [DUR_W-1:0]         out_largest,
  output logic [DUR_W-1:0]         out_nop_base,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [IW-1:0]     clr_idx_r, clr_idx_nxt;
  logic              enable_r;
  logic [CNT_W-1:0]  count_limit_r;
  logic [DUR_W-1:0]  base_r;

  req_t              req_r;
  logic [IW-1:0]     idx_r;
  logic [IW-1:0]     rd_idx;
  logic              accept;

  entry_t            rd_entry;
  entry_t            new_entry;
  entry_t            view;
  logic              upd_we;
  logic [DUR_W-1:0]  base_nxt;
  cfg_t              cfg;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  entry_t            mem_wdata;

  logic              out_valid_r;
  entry_t            out_entry_r;
  logic [DUR_W-1:0]  out_base_r;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // The program counter is taken modulo the table depth.
  if (ENTRIES >= (1 << IDX_W)) begin : g_direct
    assign rd_idx = IW'(in_entry_index);
  end else begin : g_mod
    localparam int RSH = 24;
    localparam logic [RSH:0] RECIP = (RSH + 1)'(((1 << RSH) + ENTRIES - 1) / ENTRIES);
    logic [IDX_W+RSH:0] prod;
    logic [IDX_W-1:0]   quo;
    logic [RSH-1:0]     rem;
    // Reciprocal with 24 fractional bits is exact for every 12-bit index.
    assign prod   = (IDX_W + RSH + 1)'(in_entry_index) * (IDX_W + RSH + 1)'(RECIP);
    assign quo    = prod[RSH +: IDX_W];
    assign rem    = RSH'(in_entry_index) - RSH'(quo) * RSH'(ENTRIES);
    assign rd_idx = rem[IW-1:0];
  end

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      enable_r    <= 1'b0;
      count_limit_r <= RESET_COUNT_LIMIT;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= (state_r == ST_UPDATE);
      if (state_r == ST_UPDATE) begin
        base_r <= base_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE:      enable_r      <= cfg_wdata[0];
          CFG_COUNT_LIMIT: count_limit_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Request fields and the square are captured as the entry is read.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.func     <= in_func;
      req_r.opcode   <= in_opcode;
      req_r.duration <= in_duration;
      req_r.square   <= SQ_W'(in_duration) * SQ_W'(in_duration);
      idx_r          <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) begin
      out_entry_r <= view;
      out_base_r  <= base_nxt;
    end
  end

  assign cfg.enable      = enable_r;
  assign cfg.count_limit = count_limit_r;

  assign mem_we    = (state_r == ST_CLEAR) || ((state_r == ST_UPDATE) && upd_we);
  assign mem_waddr = (state_r == ST_CLEAR) ? clr_idx_r : idx_r;
  assign mem_wdata = (state_r == ST_CLEAR) ? entry_t'('0) : new_entry;

  ptst_mem #(
    .DEPTH (ENTRIES),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (rd_entry)
  );

  ptst_upd u_upd (
    .old_entry     (rd_entry),
    .req           (req_r),
    .cfg           (cfg),
    .base_cost     (base_r),
    .new_entry     (new_entry),
    .wr_en         (upd_we),
    .view          (view),
    .base_cost_nxt (base_nxt)
  );

  assign out_valid         = out_valid_r;
  assign out_count         = out_entry_r.count;
  assign out_entry_opcode  = out_entry_r.opcode;
  assign out_total         = out_entry_r.total;
  assign out_total_squares = out_entry_r.squares;
  assign out_smallest      = out_entry_r.smallest;
  assign out_largest       = out_entry_r.largest;
  assign out_nop_base      = out_base_r;

  // Every accepted item yields its result beat, through the update state and the out_valid register.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid_r)
    else $error("result beat missing after accepted item");

  // A result beat only follows an update cycle.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_UPDATE))
    else $error("result beat without update");

  // The table is never written while idle.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("table written while idle");

endmodule

`default_nettype wire
